FILE: rtl/sesm_pkg.sv
// Shared constants, types and exp table generator for the stereo soft-clip mixer.
package sesm_pkg;

  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int SAMPLE_BITS_DEF    = 16;

  localparam int DRIVE_W    = 11;
  localparam int MIX_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX   = 1'd1;

  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 11'd256;
  localparam logic [MIX_W-1:0]   MIX_RESET   = 9'd256;
  localparam logic [MIX_W-1:0]   MIX_FULL    = 9'd256;

  // Register stages from start to the output strobe.
  localparam int PIPE_DEPTH = 6;

  // Table entries are unsigned Q1.30, never above 1.0.
  localparam int          ROM_W   = 31;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [MIX_W-1:0]   mix;
  } cfg_t;

  // exp(-8*k/2^tb) in Q1.30: ratio from a truncated 25-term series, then
  // k repeated multiplications rounded half up. Evaluated at elaboration.
  function automatic logic [63:0] exp_entry(input int tb, input int k);
    logic [63:0]        h;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        ratio;
    logic [63:0]        acc;
    h    = 64'd1 << (33 - tb);
    term = ONE_Q30;
    sum  = $signed(ONE_Q30);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * h) >> 30) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    ratio = $unsigned(sum);
    acc   = ONE_Q30;
    for (int j = 1; j <= k; j++) begin
      acc = (acc * ratio + (64'd1 << 29)) >> 30;
    end
    return acc;
  endfunction

endpackage

FILE: rtl/sesm_chan.sv
// One channel of the soft-clip datapath: drive, table lookup, interpolation, blend.
module sesm_chan #(
  parameter int EXP_TABLE_BITS = sesm_pkg::EXP_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS    = sesm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  sesm_pkg::cfg_t                cfg,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int SB       = SAMPLE_BITS;
  localparam int TB       = EXP_TABLE_BITS;
  localparam int EW       = sesm_pkg::ROM_W;
  localparam int MAG_BITS = SB + 10;
  localparam int FB       = MAG_BITS - TB;
  localparam int HALF_LEN = 1 << (TB - 1);
  localparam int EVEN_LEN = HALF_LEN + 1;
  localparam int ODD_LEN  = HALF_LEN;
  localparam int ACC_W    = SB + 12;

  localparam logic [EW-1:0] ONE   = EW'(sesm_pkg::ONE_Q30);
  localparam logic [EW:0]   W_RND = (EW + 1)'(1) << (30 - SB);
  localparam logic signed [ACC_W-1:0] MIX_RND = ACC_W'(128);
  localparam logic signed [ACC_W-1:0] S_MAX   = ACC_W'((1 << (SB - 1)) - 1);
  localparam logic signed [ACC_W-1:0] S_MIN   = -S_MAX - ACC_W'(1);

  // Table split into even and odd entries so that T[i] and T[i+1] come from
  // different banks with one read each.
  logic [EW-1:0] rom_even [EVEN_LEN];
  logic [EW-1:0] rom_odd  [ODD_LEN];

  for (genvar g = 0; g < EVEN_LEN; g++) begin : g_even
    assign rom_even[g] = EW'(sesm_pkg::exp_entry(TB, 2 * g));
  end
  for (genvar g = 0; g < ODD_LEN; g++) begin : g_odd
    assign rom_odd[g] = EW'(sesm_pkg::exp_entry(TB, 2 * g + 1));
  end

  // Stage 1: magnitude times drive.
  logic                    neg_nxt;
  logic [SB-1:0]           mag_nxt;
  logic [SB+10:0]          prod_full;
  logic [MAG_BITS-1:0]     s1_prod_r;
  logic                    s1_neg_r;
  logic signed [SB-1:0]    s1_dry_r;

  always_comb begin
    neg_nxt   = x_i[SB-1];
    mag_nxt   = neg_nxt ? SB'(-x_i) : SB'(x_i);
    prod_full = {11'd0, mag_nxt} * {SB'(0), cfg.drive};
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= prod_full[MAG_BITS-1:0];
    s1_neg_r  <= neg_nxt;
    s1_dry_r  <= x_i;
  end

  // Stage 2: registered table read.
  logic [TB-1:0]         idx;
  logic [TB-1:0]         even_addr;
  logic [TB-2:0]         odd_addr;
  logic [EW-1:0]         s2_even_r;
  logic [EW-1:0]         s2_odd_r;
  logic                  s2_lsb_r;
  logic [FB-1:0]         s2_frac_r;
  logic                  s2_neg_r;
  logic signed [SB-1:0]  s2_dry_r;

  always_comb begin
    idx       = s1_prod_r[MAG_BITS-1 -: TB];
    odd_addr  = idx[TB-1:1];
    even_addr = {1'b0, idx[TB-1:1]} + TB'(idx[0]);
  end

  always_ff @(posedge clk) begin
    s2_even_r <= rom_even[even_addr];
    s2_odd_r  <= rom_odd[odd_addr];
    s2_lsb_r  <= idx[0];
    s2_frac_r <= s1_prod_r[FB-1:0];
    s2_neg_r  <= s1_neg_r;
    s2_dry_r  <= s1_dry_r;
  end

  // Stage 3: slope times fraction.
  logic [EW-1:0]         hi_nxt;
  logic [EW-1:0]         lo_nxt;
  logic [EW-1:0]         diff_nxt;
  logic [EW+FB-1:0]      s3_ip_r;
  logic [EW-1:0]         s3_hi_r;
  logic                  s3_neg_r;
  logic signed [SB-1:0]  s3_dry_r;

  always_comb begin
    hi_nxt   = s2_lsb_r ? s2_odd_r  : s2_even_r;
    lo_nxt   = s2_lsb_r ? s2_even_r : s2_odd_r;
    diff_nxt = hi_nxt - lo_nxt;
  end

  always_ff @(posedge clk) begin
    s3_ip_r  <= {FB'(0), diff_nxt} * {EW'(0), s2_frac_r};
    s3_hi_r  <= hi_nxt;
    s3_neg_r <= s2_neg_r;
    s3_dry_r <= s2_dry_r;
  end

  // Stage 4: 1 - exp, round to sample precision, restore sign.
  logic [EW-1:0]         e_nxt;
  logic [EW:0]           wsum_nxt;
  logic [SB:0]           w_nxt;
  logic signed [SB:0]    wet_nxt;
  logic signed [SB:0]    s4_wet_r;
  logic signed [SB-1:0]  s4_dry_r;

  always_comb begin
    e_nxt    = s3_hi_r - s3_ip_r[EW+FB-1:FB];
    wsum_nxt = {1'b0, ONE - e_nxt} + W_RND;
    w_nxt    = wsum_nxt[EW:31-SB];
    wet_nxt  = s3_neg_r ? -$signed(w_nxt) : $signed(w_nxt);
  end

  always_ff @(posedge clk) begin
    s4_wet_r <= wet_nxt;
    s4_dry_r <= s3_dry_r;
  end

  // Stage 5: dry and wet weights.
  logic [sesm_pkg::MIX_W-1:0]  m_nxt;
  logic [sesm_pkg::MIX_W-1:0]  dry_wt;
  logic signed [SB+9:0]        s5_pdry_r;
  logic signed [SB+10:0]       s5_pwet_r;

  always_comb begin
    m_nxt  = (cfg.mix > sesm_pkg::MIX_FULL) ? sesm_pkg::MIX_FULL : cfg.mix;
    dry_wt = sesm_pkg::MIX_FULL - m_nxt;
  end

  always_ff @(posedge clk) begin
    s5_pdry_r <= (SB + 10)'(s4_dry_r) * (SB + 10)'($signed({1'b0, dry_wt}));
    s5_pwet_r <= (SB + 11)'(s4_wet_r) * (SB + 11)'($signed({1'b0, m_nxt}));
  end

  // Stage 6: sum, round half up, clamp.
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] sh_nxt;
  logic signed [SB-1:0]    y_nxt;
  logic signed [SB-1:0]    y_r;

  always_comb begin
    acc_nxt = ACC_W'(s5_pdry_r) + ACC_W'(s5_pwet_r) + MIX_RND;
    sh_nxt  = acc_nxt >>> 8;
    if (sh_nxt > S_MAX) begin
      y_nxt = SB'(S_MAX);
    end else if (sh_nxt < S_MIN) begin
      y_nxt = SB'(S_MIN);
    end else begin
      y_nxt = SB'(sh_nxt);
    end
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
  end

  assign y_o = y_r;

endmodule

FILE: rtl/stereo_exp_softclip_mix.sv
// Top level of the stereo exponential soft-clip distortion with dry/wet blend.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+--------------------------
//   input   | in_left_in, in_right_in                 | start high, busy low
//   result  | out_left_out, out_right_out             | out_valid strobe, 1 cycle
//   config  | cfg_we, cfg_index, cfg_data             | write when cfg_we high
//
// A request is taken in every cycle in which start is high; busy stays low
// since the datapath is fully pipelined. Each result shows up, one strobe
// per request and in order, after the six stages, which are set by the drive
// multiplier, the registered table read, the interpolation multiplier, the
// rounding step, the blend multipliers and the final clamp. Reset clears
// the strobe pipeline and loads drive 1.0 and mix 1.0. The receiver cannot
// stall, so nothing is held back once it enters.
module stereo_exp_softclip_mix #(
  parameter int EXP_TABLE_BITS = sesm_pkg::EXP_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS    = sesm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [SAMPLE_BITS-1:0]        in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]        in_right_in,
  // result channel
  output logic                                 out_valid,
  output logic signed [SAMPLE_BITS-1:0]        out_left_out,
  output logic signed [SAMPLE_BITS-1:0]        out_right_out,
  // configuration
  input  logic                                 cfg_we,
  input  logic [sesm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sesm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = sesm_pkg::PIPE_DEPTH;

  // Configuration registers.
  sesm_pkg::cfg_t cfg_r;
  sesm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sesm_pkg::REG_DRIVE: cfg_nxt.drive = cfg_data[sesm_pkg::DRIVE_W-1:0];
        sesm_pkg::REG_MIX:   cfg_nxt.mix   = cfg_data[sesm_pkg::MIX_W-1:0];
        default:             cfg_nxt       = cfg_r;
      endcase
    end
  end

  // Request strobe travels alongside the data stages.
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic             accept;

  assign busy    = 1'b0;
  assign accept  = start & ~busy;
  assign vld_nxt = {vld_r[DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive <= sesm_pkg::DRIVE_RESET;
      cfg_r.mix   <= sesm_pkg::MIX_RESET;
      vld_r       <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Both channels share the settings and run in lock step.
  sesm_chan #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_left (
    .clk (clk),
    .cfg (cfg_r),
    .x_i (in_left_in),
    .y_o (out_left_out)
  );

  sesm_chan #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_right (
    .clk (clk),
    .cfg (cfg_r),
    .x_i (in_right_in),
    .y_o (out_right_out)
  );

  assign out_valid = vld_r[DEPTH-1];

endmodule
